// ----- src/mmpc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmpc_pkg: shared types and codes
// Item formats, opcode, function and status codes for the memory mapped
// program counter processor.
// ----------------------------------------------------------------------------
package mmpc_pkg;

	localparam int DATA_DEPTH_DEF    = 256;
	localparam int PROGRAM_DEPTH_DEF = 256;
	localparam int WORD_WIDTH_DEF    = 32;

	// item functions
	localparam logic [1:0] FUNC_LOAD_DATA = 2'd0;
	localparam logic [1:0] FUNC_LOAD_PROG = 2'd1;
	localparam logic [1:0] FUNC_STEP      = 2'd2;

	// opcodes
	localparam logic [3:0] OP_SET   = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_ADDI  = 4'd2;
	localparam logic [3:0] OP_SUBI  = 4'd3;
	localparam logic [3:0] OP_CPY   = 4'd4;
	localparam logic [3:0] OP_CPYI  = 4'd5;
	localparam logic [3:0] OP_CPYI2 = 4'd6;
	localparam logic [3:0] OP_JIF   = 4'd7;
	localparam logic [3:0] OP_HLT   = 4'd8;

	// result status
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_OP   = 2'd1;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic [7:0]         load_addr;
		logic signed [31:0] load_value;
		logic [3:0]         opcode;
		logic signed [31:0] first_operand;
		logic signed [31:0] second_operand;
	} req_t;

	typedef struct packed {
		logic signed [31:0] program_counter;
		logic               halted;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
	} prog_word_t;

endpackage
`default_nettype wire

// ----- src/mmpc_chan_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mmpc_chan_if: valid/ready channel
// One transfer per clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mmpc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/memory_mapped_pc_cpu_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// memory_mapped_pc_cpu_step: tiny processor with its program counter in cell 0
// Takes load and step items, keeps data cells and program words in on-chip
// memories and returns one result per item.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload             Transfer
// req      in   mmpc_pkg::req_t     req.valid & req.ready
// rsp      out  mmpc_pkg::rsp_t     rsp.valid & rsp.ready
//
// States: a load, or a step whose program counter is out of range, ends in
// IDLE; a step ends in FETCH (HLT, SET, bad opcode), RD1 (ADD, CPY, JIF),
// RD2 (ADDI, SUBI) or RD3 (CPYI via RD1, CPYI2 via RD1, RD2), one read state
// per dependent read of the single data memory port after the word fetch.
// Reset: a clearing pass writes zero to every data cell before the first
// transfer on req. Program words are not cleared.
// Stalls: the result register parts the two sides; a finished result that
// cannot enter it waits in a holding register while the block sits in DONE.
// ----------------------------------------------------------------------------
module memory_mapped_pc_cpu_step #(
	parameter int DATA_DEPTH    = mmpc_pkg::DATA_DEPTH_DEF,
	parameter int PROGRAM_DEPTH = mmpc_pkg::PROGRAM_DEPTH_DEF,
	parameter int WORD_WIDTH    = mmpc_pkg::WORD_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mmpc_chan_if.sink  req,
	mmpc_chan_if.source rsp
);

	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int W   = WORD_WIDTH;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_FETCH = 7'b0000100,
		ST_RD1   = 7'b0001000,
		ST_RD2   = 7'b0010000,
		ST_RD3   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	// memories: cell 0 is shadowed by pc_q, which serves every read of it
	logic [W-1:0]         data_mem [DATA_DEPTH];
	mmpc_pkg::prog_word_t prog_mem [PROGRAM_DEPTH];

	state_t               state_q, state_d, state_nx;
	logic [DAW-1:0]       clr_q;
	logic [W-1:0]         pc_q, pc_d;
	mmpc_pkg::prog_word_t word_q;
	logic [W-1:0]         mem_rd_q;
	logic                 rd_zero_q;
	logic [W-1:0]         v1_q, v1_d;
	logic [DAW-1:0]       dst_q, dst_d;
	mmpc_pkg::rsp_t       out_q, pend_q, fin;
	logic                 out_valid_q;

	// memory port controls
	logic                 dwe, drd;
	logic [DAW-1:0]       dwaddr, draddr;
	logic [W-1:0]         dwdata;
	logic                 pwe, prd;
	logic [PAW-1:0]       pc_idx, ld_pidx;

	// decode helpers
	logic                 fin_valid, fin_halted;
	logic [1:0]           fin_status;
	logic                 wr_inc;
	logic [DAW-1:0]       wr_idx;
	logic [W-1:0]         wr_val;
	logic [W-1:0]         cell_rd, a_w, b_w, ld_val;
	logic [DAW-1:0]       a_idx, b_idx, ld_didx;
	logic                 a_ok, b_ok, ld_dok, ld_pok;
	logic                 out_free, load_out;

	function automatic logic cell_addr_ok(input logic [W-1:0] v);
		return !v[W-1] && (64'(v) < 64'(DATA_DEPTH));
	endfunction

	assign cell_rd = rd_zero_q ? pc_q : mem_rd_q;

	assign a_w   = W'(word_q.a);
	assign b_w   = W'(word_q.b);
	assign a_idx = DAW'(word_q.a);
	assign b_idx = DAW'(word_q.b);
	assign a_ok  = $unsigned(word_q.a) < 32'(DATA_DEPTH);
	assign b_ok  = $unsigned(word_q.b) < 32'(DATA_DEPTH);

	assign ld_val  = W'(req.data.load_value);
	assign ld_didx = DAW'(req.data.load_addr);
	assign ld_pidx = PAW'(req.data.load_addr);
	assign ld_dok  = 32'(req.data.load_addr) < 32'(DATA_DEPTH);
	assign ld_pok  = 32'(req.data.load_addr) < 32'(PROGRAM_DEPTH);
	assign pc_idx  = PAW'(pc_q);

	assign req.ready = (state_q == ST_IDLE);

	// sequencer: one item at a time, one data memory read per cycle
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		v1_d       = v1_q;
		dst_d      = dst_q;
		dwe        = 1'b0;
		dwaddr     = '0;
		dwdata     = '0;
		drd        = 1'b0;
		draddr     = '0;
		pwe        = 1'b0;
		prd        = 1'b0;
		fin_valid  = 1'b0;
		fin_halted = 1'b0;
		fin_status = mmpc_pkg::STATUS_OK;
		wr_inc     = 1'b0;
		wr_idx     = '0;
		wr_val     = '0;

		case (state_q)
			ST_CLEAR: begin
				dwe    = 1'b1;
				dwaddr = clr_q;
				if (clr_q == DAW'(DATA_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					case (req.data.func)
						mmpc_pkg::FUNC_LOAD_DATA: begin
							fin_valid = 1'b1;
							if (ld_dok) begin
								dwe    = 1'b1;
								dwaddr = ld_didx;
								dwdata = ld_val;
								if (ld_didx == '0) begin
									pc_d = ld_val;
								end
							end else begin
								fin_status = mmpc_pkg::STATUS_BAD_ADDR;
							end
						end
						mmpc_pkg::FUNC_LOAD_PROG: begin
							fin_valid = 1'b1;
							if (ld_pok) begin
								pwe = 1'b1;
							end else begin
								fin_status = mmpc_pkg::STATUS_BAD_ADDR;
							end
						end
						mmpc_pkg::FUNC_STEP: begin
							if (!pc_q[W-1] && (64'(pc_q) < 64'(PROGRAM_DEPTH))) begin
								prd     = 1'b1;
								state_d = ST_FETCH;
							end else begin
								fin_valid  = 1'b1;
								fin_status = mmpc_pkg::STATUS_BAD_ADDR;
							end
						end
						default: begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_OP;
						end
					endcase
				end
			end
			ST_FETCH: begin
				case (word_q.op)
					mmpc_pkg::OP_SET: begin
						fin_valid = 1'b1;
						if (!b_ok) begin
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end else if (b_idx == '0) begin
							pc_d = a_w;
						end else begin
							dwe    = 1'b1;
							dwaddr = b_idx;
							dwdata = a_w;
							pc_d   = pc_q + W'(1);
						end
					end
					mmpc_pkg::OP_ADD: begin
						if (b_ok) begin
							drd     = 1'b1;
							draddr  = b_idx;
							state_d = ST_RD1;
						end else begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end
					end
					mmpc_pkg::OP_ADDI, mmpc_pkg::OP_SUBI, mmpc_pkg::OP_CPY,
					mmpc_pkg::OP_CPYI, mmpc_pkg::OP_CPYI2: begin
						if (a_ok && b_ok) begin
							drd     = 1'b1;
							draddr  = a_idx;
							state_d = ST_RD1;
						end else begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end
					end
					mmpc_pkg::OP_JIF: begin
						if (a_ok) begin
							drd     = 1'b1;
							draddr  = a_idx;
							state_d = ST_RD1;
						end else begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end
					end
					mmpc_pkg::OP_HLT: begin
						fin_valid  = 1'b1;
						fin_halted = 1'b1;
					end
					default: begin
						fin_valid  = 1'b1;
						fin_status = mmpc_pkg::STATUS_BAD_OP;
					end
				endcase
			end
			ST_RD1: begin
				case (word_q.op)
					mmpc_pkg::OP_ADD: begin
						wr_inc = 1'b1;
						wr_idx = b_idx;
						wr_val = cell_rd + a_w;
					end
					mmpc_pkg::OP_CPY: begin
						wr_inc = 1'b1;
						wr_idx = b_idx;
						wr_val = cell_rd;
					end
					mmpc_pkg::OP_JIF: begin
						fin_valid = 1'b1;
						pc_d = ((cell_rd == '0) || cell_rd[W-1]) ? b_w : pc_q + W'(1);
					end
					mmpc_pkg::OP_ADDI, mmpc_pkg::OP_SUBI: begin
						v1_d    = cell_rd;
						drd     = 1'b1;
						draddr  = b_idx;
						state_d = ST_RD2;
					end
					mmpc_pkg::OP_CPYI, mmpc_pkg::OP_CPYI2: begin
						if (cell_addr_ok(cell_rd)) begin
							v1_d  = cell_rd;
							dst_d = b_idx;
							drd   = 1'b1;
							if (word_q.op == mmpc_pkg::OP_CPYI) begin
								draddr  = DAW'(cell_rd);
								state_d = ST_RD3;
							end else begin
								draddr  = b_idx;
								state_d = ST_RD2;
							end
						end else begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end
					end
					default: begin
						fin_valid  = 1'b1;
						fin_status = mmpc_pkg::STATUS_BAD_OP;
					end
				endcase
			end
			ST_RD2: begin
				case (word_q.op)
					mmpc_pkg::OP_ADDI: begin
						wr_inc = 1'b1;
						wr_idx = b_idx;
						wr_val = v1_q + cell_rd;
					end
					mmpc_pkg::OP_SUBI: begin
						wr_inc = 1'b1;
						wr_idx = b_idx;
						wr_val = v1_q - cell_rd;
					end
					mmpc_pkg::OP_CPYI2: begin
						if (cell_addr_ok(cell_rd)) begin
							dst_d   = DAW'(cell_rd);
							drd     = 1'b1;
							draddr  = DAW'(v1_q);
							state_d = ST_RD3;
						end else begin
							fin_valid  = 1'b1;
							fin_status = mmpc_pkg::STATUS_BAD_ADDR;
						end
					end
					default: begin
						fin_valid  = 1'b1;
						fin_status = mmpc_pkg::STATUS_BAD_OP;
					end
				endcase
			end
			ST_RD3: begin
				wr_inc = 1'b1;
				wr_idx = dst_q;
				wr_val = cell_rd;
			end
			ST_DONE: begin
				// hold until the result register frees up
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// write the target cell, then advance cell 0 as it stands after the write
		if (wr_inc) begin
			fin_valid = 1'b1;
			dwe       = 1'b1;
			dwaddr    = wr_idx;
			dwdata    = wr_val;
			pc_d      = ((wr_idx == '0) ? wr_val : pc_q) + W'(1);
		end

		if (fin_valid) begin
			state_d = ST_IDLE;
		end

		fin.program_counter = 32'($signed(pc_d));
		fin.halted          = fin_halted;
		fin.status          = fin_status;
	end

	assign out_free = !out_valid_q || rsp.ready;
	assign load_out = (fin_valid || (state_q == ST_DONE)) && out_free;

	always_comb begin
		state_nx = state_d;
		if (fin_valid && !out_free) begin
			state_nx = ST_DONE;
		end else if ((state_q == ST_DONE) && out_free) begin
			state_nx = ST_IDLE;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			pc_q    <= pc_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + DAW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		v1_q  <= v1_d;
		dst_q <= dst_d;
		if (fin_valid && !out_free) begin
			pend_q <= fin;
		end
		if (load_out) begin
			out_q <= (state_q == ST_DONE) ? pend_q : fin;
		end
	end

	// data memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (dwe) begin
			data_mem[dwaddr] <= dwdata;
		end
		if (drd) begin
			mem_rd_q  <= data_mem[draddr];
			rd_zero_q <= (draddr == '0);
		end
	end

	// program memory: written by loads, read once per step
	always_ff @(posedge clk) begin
		if (pwe) begin
			prog_mem[ld_pidx] <= '{op: req.data.opcode, a: req.data.first_operand,
			                       b: req.data.second_operand};
		end
		if (prd) begin
			word_q <= prog_mem[pc_idx];
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
`default_nettype wire
